>>> sv/rlfs_pkg.sv
// rlfs_pkg: shared types, phase codes, register indexes and the colour table
// for the rgb led fade and flash sequencer
// no dependencies
package rlfs_pkg;

  localparam int TABLE_SIZE  = 7;
  localparam int COLOR_COUNT = 7;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] FLASH_CMD  = 8'd9;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_RED   = 3'd1;
  localparam logic [2:0] PH_GREEN = 3'd2;
  localparam logic [2:0] PH_BLUE  = 3'd3;
  localparam logic [2:0] PH_OFF   = 3'd4;
  localparam logic [2:0] PH_ON    = 3'd5;

  localparam logic [1:0] REG_STEP_TICKS    = 2'd0;
  localparam logic [1:0] REG_FLASH_TICKS   = 2'd1;
  localparam logic [1:0] REG_FLASH_REPEATS = 2'd2;

  localparam logic [15:0] STEP_TICKS_RST    = 16'd10;
  localparam logic [15:0] FLASH_TICKS_RST   = 16'd1000;
  localparam logic [3:0]  FLASH_REPEATS_RST = 4'd6;

  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [2:0]  shown;
    logic [2:0]  target;
    logic [15:0] tick_count;
    logic [3:0]  flash_left;
  } seq_state_t;

  typedef struct packed {
    logic [15:0] step_ticks;
    logic [15:0] flash_ticks;
    logic [3:0]  flash_repeats;
  } seq_cfg_t;

  // channel 0 red, 1 green, 2 blue; out-of-table index reads entry zero
  function automatic logic [7:0] palette(input logic [2:0] idx, input logic [1:0] ch);
    logic [23:0] rgb;
    begin
      case (idx)
        3'd1:    rgb = {8'd255, 8'd255, 8'd0};
        3'd2:    rgb = {8'd255, 8'd96, 8'd0};
        3'd3:    rgb = {8'd255, 8'd0, 8'd0};
        3'd4:    rgb = {8'd0, 8'd255, 8'd0};
        3'd5:    rgb = {8'd0, 8'd0, 8'd255};
        3'd6:    rgb = {8'd255, 8'd255, 8'd255};
        default: rgb = {8'd255, 8'd128, 8'd128};
      endcase
      case (ch)
        2'd0:    palette = rgb[23:16];
        2'd1:    palette = rgb[15:8];
        default: palette = rgb[7:0];
      endcase
    end
  endfunction

  localparam seq_state_t STATE_RST = '{
    phase:      PH_IDLE,
    red:        8'd255,
    green:      8'd128,
    blue:       8'd128,
    shown:      3'd0,
    target:     3'd0,
    tick_count: 16'd0,
    flash_left: 4'd0
  };

endpackage

>>> sv/rlfs_step.sv
// rlfs_step: next-state logic for one transaction (tick or command byte)
// depends on rlfs_pkg
module rlfs_step import rlfs_pkg::*; (
  input  seq_state_t cur,
  input  seq_cfg_t   cfg,
  input  logic       action,
  input  logic [7:0] cmd_byte,
  output seq_state_t nxt,
  output logic       accepted
);

  logic [15:0] tick_inc;
  logic [15:0] limit;
  logic        expire;
  logic [1:0]  ch;
  logic [7:0]  lvl;
  logic [7:0]  goal;
  logic [7:0]  lvl_new;
  logic [3:0]  flash_dec;
  logic [7:0]  q;
  logic        is_digit;
  logic        is_flash;

  assign tick_inc  = cur.tick_count + 16'd1;
  assign limit     = (cur.phase >= PH_OFF) ? cfg.flash_ticks : cfg.step_ticks;
  assign expire    = !(tick_inc < limit);
  assign ch        = 2'(cur.phase - PH_RED);
  assign goal      = palette(cur.target, ch);
  assign flash_dec = cur.flash_left - 4'd1;
  assign q         = cmd_byte - ASCII_ZERO;
  assign is_digit  = (cmd_byte >= ASCII_ZERO) && (q < 8'(COLOR_COUNT)) && (q < 8'(TABLE_SIZE));
  assign is_flash  = (cmd_byte >= ASCII_ZERO) && (q == FLASH_CMD);

  always_comb begin
    case (ch)
      2'd0:    lvl = cur.red;
      2'd1:    lvl = cur.green;
      default: lvl = cur.blue;
    endcase
    if (lvl < goal) begin
      lvl_new = lvl + 8'd1;
    end else if (lvl > goal) begin
      lvl_new = lvl - 8'd1;
    end else begin
      lvl_new = lvl;
    end
  end

  always_comb begin
    nxt      = cur;
    accepted = 1'b0;
    if (action) begin
      if (cur.phase == PH_IDLE) begin
        if (is_digit) begin
          accepted       = 1'b1;
          nxt.target     = q[2:0];
          nxt.red        = palette(cur.shown, 2'd0);
          nxt.green      = palette(cur.shown, 2'd1);
          nxt.blue       = palette(cur.shown, 2'd2);
          nxt.tick_count = '0;
          nxt.phase      = PH_RED;
        end else if (is_flash) begin
          accepted       = 1'b1;
          nxt.flash_left = (cfg.flash_repeats != 4'd0) ? cfg.flash_repeats : 4'd1;
          nxt.tick_count = '0;
          nxt.red        = '0;
          nxt.green      = '0;
          nxt.blue       = '0;
          nxt.phase      = PH_OFF;
        end
      end
    end else if (cur.phase != PH_IDLE) begin
      nxt.tick_count = tick_inc;
      if (expire) begin
        nxt.tick_count = '0;
        unique case (cur.phase) inside
          PH_OFF: begin
            nxt.phase = PH_ON;
            nxt.red   = palette(cur.shown, 2'd0);
            nxt.green = palette(cur.shown, 2'd1);
            nxt.blue  = palette(cur.shown, 2'd2);
          end
          PH_ON: begin
            nxt.flash_left = flash_dec;
            if (flash_dec == 4'd0) begin
              nxt.phase = PH_IDLE;
            end else begin
              nxt.phase = PH_OFF;
              nxt.red   = '0;
              nxt.green = '0;
              nxt.blue  = '0;
            end
          end
          PH_RED, PH_GREEN, PH_BLUE: begin
            if (lvl != goal) begin
              case (ch)
                2'd0:    nxt.red   = lvl_new;
                2'd1:    nxt.green = lvl_new;
                default: nxt.blue  = lvl_new;
              endcase
            end else if (cur.phase == PH_BLUE) begin
              nxt.phase = PH_IDLE;
              nxt.shown = cur.target;
            end else begin
              nxt.phase = cur.phase + 3'd1;
            end
          end
          default: nxt.phase = PH_IDLE;
        endcase
      end
    end
  end

endmodule

>>> sv/rgb_led_fade_and_flash_sequencer.sv
// rgb_led_fade_and_flash_sequencer: top level, state and config registers
// depends on rlfs_pkg and rlfs_step
//
//   channel  handshake            payload
//   in       in_valid/in_ready    action, cmd_byte
//   out      out_valid/out_ready  red_level, green_level, blue_level,
//                                 busy_res, accepted, color_index
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle unless the output stalls: the sequencer state
// updates at the accepting edge and its result shows on the next cycle from
// the state registers. in_ready is high whenever the result register is
// empty or being drained, so input and output can move in the same cycle;
// a stalled result holds. cfg_ready is always high. reset restores colour
// entry zero, idle phase and the default register values.
module rgb_led_fade_and_flash_sequencer import rlfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  cmd_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_level,
  output logic [7:0]  green_level,
  output logic [7:0]  blue_level,
  output logic        busy_res,
  output logic        accepted,
  output logic [2:0]  color_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  seq_state_t state;
  seq_state_t state_next;
  seq_cfg_t   cfg;
  logic       acc_next;
  logic       in_fire;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  rlfs_step u_step (
    .cur      (state),
    .cfg      (cfg),
    .action   (action),
    .cmd_byte (cmd_byte),
    .nxt      (state_next),
    .accepted (acc_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_RST;
      out_valid <= 1'b0;
      accepted  <= 1'b0;
    end else begin
      if (in_fire) begin
        state     <= state_next;
        accepted  <= acc_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_ticks    <= STEP_TICKS_RST;
      cfg.flash_ticks   <= FLASH_TICKS_RST;
      cfg.flash_repeats <= FLASH_REPEATS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STEP_TICKS:    cfg.step_ticks    <= cfg_data;
        REG_FLASH_TICKS:   cfg.flash_ticks   <= cfg_data;
        REG_FLASH_REPEATS: cfg.flash_repeats <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // levels and status come straight from the state, which holds while stalled
  assign red_level   = state.red;
  assign green_level = state.green;
  assign blue_level  = state.blue;
  assign busy_res    = (state.phase != PH_IDLE);
  assign color_index = state.shown;

endmodule
